// File: hw/rtl/rsnh_pkg.sv
// Shared types and constants of the ray and sphere nearest hit unit.
// Used by the channel interfaces, the sphere cell and the top level.
package rsnh_pkg;

	localparam int POS_W  = 32;
	localparam int DIR_W  = 16;
	localparam int RAD_W  = 31;
	localparam int SLOT_W = 3;
	localparam int DIST_W = 48;
	localparam int STEP_W = 8;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_TRACE = 1'b1;

	localparam logic [RAD_W-1:0] DIST_MAX = {RAD_W{1'b1}};

	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic signed [DIR_W-1:0] dir_t;
	typedef logic [RAD_W-1:0]        rad_t;
	typedef logic [SLOT_W-1:0]       slot_t;
	typedef logic [STEP_W-1:0]       step_t;

	typedef struct packed {
		pos_t center_x;
		pos_t center_y;
		pos_t center_z;
		rad_t radius;
	} sphere_t;

	typedef struct packed {
		pos_t origin_x;
		pos_t origin_y;
		pos_t origin_z;
		dir_t dir_x;
		dir_t dir_y;
		dir_t dir_z;
	} ray_t;

	typedef struct packed {
		logic  load;
		slot_t slot;
		logic  calc;
		logic  scan;
		step_t step;
	} cell_ctrl_t;

	typedef struct packed {
		logic              vld;
		slot_t             idx;
		logic [DIST_W-1:0] distance;
	} cand_t;

endpackage

// File: hw/rtl/rsnh_in_if.sv
// Input channel of the ray and sphere nearest hit unit: load and trace transactions.
// Depends on rsnh_pkg.
interface rsnh_in_if;
	import rsnh_pkg::*;

	logic  valid;
	logic  ready;
	logic  action;
	slot_t sphere_slot;
	pos_t  center_x;
	pos_t  center_y;
	pos_t  center_z;
	rad_t  radius;
	pos_t  origin_x;
	pos_t  origin_y;
	pos_t  origin_z;
	dir_t  dir_x;
	dir_t  dir_y;
	dir_t  dir_z;

	modport source (
		output valid, action, sphere_slot, center_x, center_y, center_z, radius,
		output origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		input  ready
	);
	modport sink (
		input  valid, action, sphere_slot, center_x, center_y, center_z, radius,
		input  origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		output ready
	);
endinterface

// File: hw/rtl/rsnh_out_if.sv
// Result channel of the ray and sphere nearest hit unit.
// Depends on rsnh_pkg.
interface rsnh_out_if;
	import rsnh_pkg::*;

	logic  valid;
	logic  ready;
	logic  hit;
	slot_t nearest_index;
	rad_t  distance;

	modport source (output valid, hit, nearest_index, distance, input ready);
	modport sink (input valid, hit, nearest_index, distance, output ready);
endinterface

// File: hw/rtl/ray_sphere_nearest_hit_unit.sv
// Ray and sphere nearest hit unit, top level: sequencer, ray register, cell chain
// and result register. Depends on rsnh_pkg, rsnh_in_if, rsnh_out_if and rsnh_cell.
//
// The input channel carries load and trace transactions. A load writes one sphere
// slot and gives no result. A trace starts a computation over all NUM_SPHERES cells
// at once and gives exactly one result transaction on the output channel: hit flag,
// slot of the nearest hit and its saturated distance. A trace first runs the cell
// work, whose length is set by the bit-serial square root in each cell and its width
// RW (38 at the default fraction width); then the nearest candidate ripples down the
// chain of NUM_SPHERES cells, and then it is written to the result register.
// One transaction is in work at a time; the input is ready again as soon as the
// result register is loaded, even if that result has not been taken yet, so a new
// trace cannot be accepted before the last one is through.
// When the receiver stalls, a finished trace waits until the result register is free.
// Reset clears the sequencer, the result valid flag and every sphere radius, so
// all slots read as empty until loaded.
module ray_sphere_nearest_hit_unit #(
	parameter int NUM_SPHERES = 8,
	parameter int FRAC_BITS   = 14
) (
	input logic      clk,
	input logic      arst_n,
	rsnh_in_if.sink  in_ch,
	rsnh_out_if.source out_ch
);
	import rsnh_pkg::*;

	localparam int OW    = POS_W + 1;
	localparam int BW    = OW + DIR_W + 2 - FRAC_BITS;
	localparam int QSW   = 2 * OW + 2;
	localparam int DISCW = ((2 * BW > QSW) ? 2 * BW : QSW) + 1;
	localparam int RW    = (DISCW + 1) / 2;
	localparam int CALC_LEN = 6 + RW;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CALC = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t     state_q;
	step_t      cnt_q;
	ray_t       ray_q;
	cell_ctrl_t ctrl;
	sphere_t    sphere;
	cand_t      chain [NUM_SPHERES+1];
	logic       in_acc;
	logic       out_load;
	logic       out_valid_q;
	logic       hit_q;
	slot_t      index_q;
	rad_t       dist_q;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign out_load    = (state_q == ST_DONE) && (!out_valid_q || out_ch.ready);

	assign sphere.center_x = in_ch.center_x;
	assign sphere.center_y = in_ch.center_y;
	assign sphere.center_z = in_ch.center_z;
	assign sphere.radius   = in_ch.radius;

	assign ctrl.load = in_acc && (in_ch.action == ACT_LOAD);
	assign ctrl.slot = in_ch.sphere_slot;
	assign ctrl.calc = (state_q == ST_CALC);
	assign ctrl.scan = (state_q == ST_SCAN);
	assign ctrl.step = cnt_q;

	assign chain[0] = '0;

	for (genvar i = 0; i < NUM_SPHERES; i++) begin : g_cell
		rsnh_cell #(
			.FRAC_BITS  (FRAC_BITS),
			.CELL_INDEX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.sphere   (sphere),
			.ray      (ray_q),
			.best_in  (chain[i]),
			.best_out (chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (in_ch.action == ACT_TRACE)) begin
						state_q <= ST_CALC;
						cnt_q   <= '0;
					end
				end
				ST_CALC: begin
					if (cnt_q == STEP_W'(CALC_LEN - 1)) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SCAN: begin
					if (cnt_q == STEP_W'(NUM_SPHERES - 1)) begin
						state_q <= ST_DONE;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && (in_ch.action == ACT_TRACE)) begin
			ray_q.origin_x <= in_ch.origin_x;
			ray_q.origin_y <= in_ch.origin_y;
			ray_q.origin_z <= in_ch.origin_z;
			ray_q.dir_x    <= in_ch.dir_x;
			ray_q.dir_y    <= in_ch.dir_y;
			ray_q.dir_z    <= in_ch.dir_z;
		end
		if (out_load) begin
			hit_q <= chain[NUM_SPHERES].vld;
			if (!chain[NUM_SPHERES].vld) begin
				index_q <= '0;
				dist_q  <= '0;
			end else if (chain[NUM_SPHERES].distance > DIST_W'(DIST_MAX)) begin
				index_q <= chain[NUM_SPHERES].idx;
				dist_q  <= DIST_MAX;
			end else begin
				index_q <= chain[NUM_SPHERES].idx;
				dist_q  <= chain[NUM_SPHERES].distance[RAD_W-1:0];
			end
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.hit           = hit_q;
	assign out_ch.nearest_index = index_q;
	assign out_ch.distance      = dist_q;

`ifndef SYNTHESIS
	a_trace_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (in_ch.action == ACT_TRACE)) |=> (state_q == ST_CALC))
		else $error("Accepted trace did not start the computation.");
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(state_q == ST_DONE))
		else $error("Result appeared without a finished trace.");
	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.hit) |->
		((out_ch.nearest_index == '0) && (out_ch.distance == '0)))
		else $error("Miss result carries a nonzero index or distance.");
`endif
endmodule

// File: hw/rtl/rsnh_cell.sv
// One sphere cell: holds one table slot, computes the near root for the current ray
// and merges its candidate into the running nearest hit passed along the chain.
// Depends on rsnh_pkg.
module rsnh_cell #(
	parameter int FRAC_BITS  = 14,
	parameter int CELL_INDEX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rsnh_pkg::cell_ctrl_t ctrl,
	input  rsnh_pkg::sphere_t   sphere,
	input  rsnh_pkg::ray_t      ray,
	input  rsnh_pkg::cand_t     best_in,
	output rsnh_pkg::cand_t     best_out
);
	import rsnh_pkg::*;

	localparam int OW    = POS_W + 1;
	localparam int PW    = OW + DIR_W;
	localparam int SW    = PW + 2;
	localparam int BW    = SW - FRAC_BITS;
	localparam int QW    = 2 * OW;
	localparam int QSW   = QW + 2;
	localparam int RRW   = 2 * RAD_W;
	localparam int BBW   = 2 * BW;
	localparam int DISCW = ((BBW > QSW) ? BBW : QSW) + 1;
	localparam int RW    = (DISCW + 1) / 2;
	localparam int TW    = ((BW > RW) ? BW : RW) + 2;
	localparam int ST_OC    = 0;
	localparam int ST_MUL   = 1;
	localparam int ST_SUM   = 2;
	localparam int ST_BB    = 3;
	localparam int ST_DISC  = 4;
	localparam int ST_ROOT  = 5;
	localparam int ST_FINAL = ST_ROOT + RW;
	localparam bit LOADABLE = CELL_INDEX < (1 << SLOT_W);

	pos_t                   cx_q, cy_q, cz_q;
	rad_t                   radius_q;
	logic signed [OW-1:0]   ocx_q, ocy_q, ocz_q;
	logic signed [PW-1:0]   px_q, py_q, pz_q;
	logic signed [QW-1:0]   qx_q, qy_q, qz_q;
	logic [RRW-1:0]         rr_q;
	logic signed [BW-1:0]   b_q;
	logic signed [QSW-1:0]  q_q;
	logic signed [BBW-1:0]  bb_q;
	logic [2*RW-1:0]        rad_q;
	logic [RW+1:0]          rem_q;
	logic [RW-1:0]          root_q;
	logic                   pos_q;
	cand_t                  own_q;
	cand_t                  best_q;

	logic signed [SW-1:0]   dot_sum;
	logic signed [SW-1:0]   dot_shr;
	logic signed [DISCW-1:0] disc;
	logic                   disc_pos;
	logic [RW+3:0]          rem_sh;
	logic [RW+3:0]          trial;
	logic signed [TW-1:0]   t_val;
	logic                   take_own;

	assign dot_sum = SW'(px_q) + SW'(py_q) + SW'(pz_q);
	assign dot_shr = dot_sum >>> FRAC_BITS;
	assign disc    = DISCW'(bb_q) + DISCW'(q_q);
	assign disc_pos = !disc[DISCW-1] && (disc != '0) && (radius_q != '0);
	assign rem_sh  = {rem_q, rad_q[2*RW-1 -: 2]};
	assign trial   = (RW+4)'({root_q, 2'b01});
	assign t_val   = -TW'(b_q) - TW'($unsigned(root_q));
	assign take_own = own_q.vld && (!best_in.vld || (own_q.distance < best_in.distance));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
		end else if (LOADABLE && ctrl.load && (ctrl.slot == SLOT_W'(CELL_INDEX))) begin
			radius_q <= sphere.radius;
		end
	end

	always_ff @(posedge clk) begin
		if (LOADABLE && ctrl.load && (ctrl.slot == SLOT_W'(CELL_INDEX))) begin
			cx_q <= sphere.center_x;
			cy_q <= sphere.center_y;
			cz_q <= sphere.center_z;
		end
		if (ctrl.calc) begin
			if (ctrl.step == STEP_W'(ST_OC)) begin
				ocx_q <= OW'(ray.origin_x) - OW'(cx_q);
				ocy_q <= OW'(ray.origin_y) - OW'(cy_q);
				ocz_q <= OW'(ray.origin_z) - OW'(cz_q);
			end
			if (ctrl.step == STEP_W'(ST_MUL)) begin
				px_q <= PW'(ocx_q) * PW'(ray.dir_x);
				py_q <= PW'(ocy_q) * PW'(ray.dir_y);
				pz_q <= PW'(ocz_q) * PW'(ray.dir_z);
				qx_q <= QW'(ocx_q) * QW'(ocx_q);
				qy_q <= QW'(ocy_q) * QW'(ocy_q);
				qz_q <= QW'(ocz_q) * QW'(ocz_q);
				rr_q <= RRW'(radius_q) * RRW'(radius_q);
			end
			if (ctrl.step == STEP_W'(ST_SUM)) begin
				b_q <= dot_shr[BW-1:0];
				q_q <= QSW'($signed({1'b0, rr_q})) - QSW'(qx_q) - QSW'(qy_q) - QSW'(qz_q);
			end
			if (ctrl.step == STEP_W'(ST_BB)) begin
				bb_q <= BBW'(b_q) * BBW'(b_q);
			end
			if (ctrl.step == STEP_W'(ST_DISC)) begin
				rad_q  <= (2*RW)'($unsigned(disc));
				rem_q  <= '0;
				root_q <= '0;
				pos_q  <= disc_pos;
			end
			if ((ctrl.step >= STEP_W'(ST_ROOT)) && (ctrl.step < STEP_W'(ST_FINAL))) begin
				rad_q <= {rad_q[2*RW-3:0], 2'b00};
				if (rem_sh >= trial) begin
					rem_q  <= (RW+2)'(rem_sh - trial);
					root_q <= {root_q[RW-2:0], 1'b1};
				end else begin
					rem_q  <= (RW+2)'(rem_sh);
					root_q <= {root_q[RW-2:0], 1'b0};
				end
			end
			if (ctrl.step == STEP_W'(ST_FINAL)) begin
				own_q.vld      <= pos_q && (t_val > 0);
				own_q.idx      <= SLOT_W'(CELL_INDEX);
				own_q.distance <= DIST_W'($unsigned(t_val));
			end
		end
		if (ctrl.scan) begin
			best_q <= take_own ? own_q : best_in;
		end
	end

	assign best_out = best_q;
endmodule

// File: bench/ray_sphere_nearest_hit_unit_chk.sv
// Checker of the ray and sphere nearest hit unit: keeps its own sphere table,
// predicts each trace result and compares it with the output channel.
// Depends on rsnh_pkg, rsnh_in_if and rsnh_out_if.
module ray_sphere_nearest_hit_unit_chk (
	input logic  clk,
	input logic  arst_n,
	rsnh_in_if   in_ch,
	rsnh_out_if  out_ch,
	output int   fail_count,
	output int   pending,
	output int   traces_seen,
	output int   hits_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import rsnh_pkg::*;

	typedef struct {
		logic  hit;
		slot_t idx;
		rad_t  distance;
	} hit_result_t;

	sphere_t     spheres[8];
	hit_result_t hit_queue[$];

	function automatic longint floor_root(logic [127:0] v);
		logic [63:0]  r;
		logic [63:0]  c;
		logic [127:0] sq;
		r = 0;
		for (int k = 63; k >= 0; k--) begin
			c = r | (64'd1 << k);
			sq = {64'd0, c} * {64'd0, c};
			if (sq <= v) r = c;
		end
		return longint'(r);
	endfunction

	function automatic hit_result_t nearest_hit(ray_t ray);
		hit_result_t res;
		longint cx, cy, cz, dot, b, t, best, rr;
		logic signed [127:0] disc;
		bit found;
		found = 0;
		best = 0;
		res.hit = 0;
		res.idx = '0;
		res.distance = '0;
		for (int i = 0; i < 8; i++) begin
			if (spheres[i].radius == 0) continue;
			cx = longint'(ray.origin_x) - longint'(spheres[i].center_x);
			cy = longint'(ray.origin_y) - longint'(spheres[i].center_y);
			cz = longint'(ray.origin_z) - longint'(spheres[i].center_z);
			dot = cx * longint'(ray.dir_x) + cy * longint'(ray.dir_y) + cz * longint'(ray.dir_z);
			b = dot >>> 14;
			rr = longint'({1'b0, spheres[i].radius});
			disc = 128'(signed'(b)) * 128'(signed'(b)) - 128'(signed'(cx)) * 128'(signed'(cx))
				- 128'(signed'(cy)) * 128'(signed'(cy)) - 128'(signed'(cz)) * 128'(signed'(cz))
				+ 128'(signed'(rr)) * 128'(signed'(rr));
			if (disc <= 0) continue;
			t = -b - floor_root(disc);
			if (t > 0 && (!found || t < best)) begin
				found = 1;
				best = t;
				res.idx = slot_t'(i);
			end
		end
		if (found) begin
			res.hit = 1;
			res.distance = best > 64'sh7FFFFFFF ? DIST_MAX : rad_t'(best);
		end
		return res;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		hit_result_t e;
		ray_t ray;
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) spheres[i] <= '0;
			hit_queue.delete();
			fail_count <= 0;
			traces_seen <= 0;
			hits_seen <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (hit_queue.size() == 0) begin
					$error("result transaction with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					e = hit_queue.pop_front();
					if (out_ch.hit != e.hit || out_ch.nearest_index != e.idx
						|| out_ch.distance != e.distance) begin
						fail_count <= fail_count + 1;
						if (out_ch.hit != e.hit)
							$error("hit: expected %0d, got %0d", e.hit, out_ch.hit);
						if (out_ch.nearest_index != e.idx)
							$error("nearest_index: expected %0d, got %0d",
								e.idx, out_ch.nearest_index);
						if (out_ch.distance != e.distance)
							$error("distance: expected %0d, got %0d", e.distance,
								out_ch.distance);
					end
					if (e.hit) hits_seen <= hits_seen + 1;
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				if (in_ch.action == ACT_LOAD) begin
					spheres[in_ch.sphere_slot] <= '{in_ch.center_x, in_ch.center_y,
						in_ch.center_z, in_ch.radius};
				end else begin
					ray = '{in_ch.origin_x, in_ch.origin_y, in_ch.origin_z,
						in_ch.dir_x, in_ch.dir_y, in_ch.dir_z};
					hit_queue.push_back(nearest_hit(ray));
					traces_seen <= traces_seen + 1;
				end
			end
		end
	end

	assign pending = hit_queue.size();
endmodule

// File: bench/ray_sphere_nearest_hit_unit_tb.sv
// Testbench top of the ray and sphere nearest hit unit: clock, reset, load and
// trace stimulus under several idling phases, and the verdict.
// Depends on rsnh_pkg, the channel interfaces, the block and its checker.
module ray_sphere_nearest_hit_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rsnh_pkg::*;

	logic clk;
	logic arst_n;
	int   fail_count, pending, traces_seen, hits_seen;
	int   send_idle_pct, recv_stall_pct;

	rsnh_in_if  in_ch ();
	rsnh_out_if out_ch ();

	ray_sphere_nearest_hit_unit dut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));

	ray_sphere_nearest_hit_unit_chk chk (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.fail_count(fail_count), .pending(pending),
		.traces_seen(traces_seen), .hits_seen(hits_seen)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("ray_sphere_nearest_hit_unit_tb: done, errors");
		$finish;
	end

	always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

	task automatic send(logic act, slot_t slot, sphere_t s, ray_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 0;
			@(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.action <= act;
		in_ch.sphere_slot <= slot;
		{in_ch.center_x, in_ch.center_y, in_ch.center_z, in_ch.radius} <= s;
		{in_ch.origin_x, in_ch.origin_y, in_ch.origin_z,
			in_ch.dir_x, in_ch.dir_y, in_ch.dir_z} <= r;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	function automatic pos_t near_pos(int span);
		return pos_t'($signed($urandom_range(2 * span)) - span);
	endfunction

	function automatic dir_t unit_dir();
		int a;
		a = $urandom_range(2);
		case ($urandom_range(3))
			0: return dir_t'(a == 0 ? 16384 : -16384);
			1: return dir_t'($signed($urandom_range(32768)) - 16384);
			2: return dir_t'(0);
			default: return dir_t'($urandom);
		endcase
	endfunction

	task automatic load_rand(slot_t slot, int span);
		sphere_t s;
		s.center_x = near_pos(span);
		s.center_y = near_pos(span);
		s.center_z = near_pos(span);
		s.radius = $urandom_range(7) == 0 ? rad_t'($urandom) : rad_t'($urandom_range(span));
		if ($urandom_range(9) == 0) s.radius = '0;
		if ($urandom_range(19) == 0) s = sphere_t'({$urandom, $urandom, $urandom, $urandom});
		send(ACT_LOAD, slot, s, '0);
	endtask

	task automatic trace_rand(int span);
		ray_t r;
		r.origin_x = near_pos(span);
		r.origin_y = near_pos(span);
		r.origin_z = near_pos(span);
		r.dir_x = unit_dir();
		r.dir_y = unit_dir();
		r.dir_z = unit_dir();
		if ($urandom_range(19) == 0) r = ray_t'({$urandom, $urandom, $urandom, $urandom});
		send(ACT_TRACE, '0, '0, r);
	endtask

	localparam pos_t ONE = 32'sd16384;
	localparam dir_t DPOS = 16'sd16384;
	localparam dir_t DNEG = -16'sd16384;

	initial begin
		int span;
		in_ch.valid = 0;
		in_ch.action = ACT_LOAD;
		in_ch.sphere_slot = '0;
		{in_ch.center_x, in_ch.center_y, in_ch.center_z, in_ch.radius} = '0;
		{in_ch.origin_x, in_ch.origin_y, in_ch.origin_z,
			in_ch.dir_x, in_ch.dir_y, in_ch.dir_z} = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send(ACT_TRACE, '0, '0, '{ONE, 0, 0, DPOS, 0, 0});
		send(ACT_LOAD, 3, '{10 * ONE, 0, 0, ONE}, '0);
		send(ACT_LOAD, 5, '{10 * ONE, 0, 0, ONE}, '0);
		send(ACT_LOAD, 1, '{20 * ONE, 0, 0, 2 * ONE}, '0);
		send(ACT_TRACE, '0, '0, '{0, 0, 0, DPOS, 0, 0});
		send(ACT_TRACE, '0, '0, '{0, 0, 0, DNEG, 0, 0});
		send(ACT_TRACE, '0, '0, '{10 * ONE, 0, 0, DPOS, 0, 0});
		send(ACT_TRACE, '0, '0, '{30 * ONE, 0, 0, DPOS, 0, 0});
		send(ACT_TRACE, '0, '0, '{0, 0, 0, 16'sd7000, 16'sd100, 16'sd0});
		send(ACT_TRACE, '0, '0, '{0, 0, 0, 16'sh7FFF, 16'sh8000, 16'sh7FFF});
		send(ACT_LOAD, 7, '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, DIST_MAX}, '0);
		send(ACT_LOAD, 0, '{32'sh80000000, 32'sh80000000, 32'sh80000000, DIST_MAX}, '0);
		send(ACT_TRACE, '0, '0, '{32'sh80000000, 32'sh80000000, 32'sh80000000,
			DPOS, DPOS, DPOS});
		send(ACT_TRACE, '0, '0, '{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
			DNEG, DPOS, DNEG});
		send(ACT_LOAD, 2, '{0, 0, 0, 0}, '0);
		send(ACT_TRACE, '0, '0, '{0, 0, 32'sh80000000, 0, 0, DPOS});
		for (int i = 0; i < 8; i++) send(ACT_LOAD, slot_t'(i), '0, '0);

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				1: begin send_idle_pct = 86; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 86; end
				3: begin send_idle_pct = 31; recv_stall_pct = 31; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			for (int n = 0; n < 170; n++) begin
				span = $urandom_range(3) == 0 ? 1 << 30 : 1 << ($urandom_range(20) + 4);
				if ($urandom_range(3) == 0) load_rand(slot_t'($urandom_range(7)), span);
				else trace_rand(span);
			end
		end
		in_ch.valid <= 0;

		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		$display("Covered %0d traces, %0d of them hits, across five idling phases.",
			traces_seen, hits_seen);
		if (fail_count == 0)
			$display("ray_sphere_nearest_hit_unit_tb: done, clean");
		else
			$display("ray_sphere_nearest_hit_unit_tb: done, errors");
		$finish;
	end
endmodule
